### src/tds_pkg.sv
`default_nettype none
package tds_pkg;
  localparam int MAX_ROWS  = 64;
  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;
  localparam int IN_BITS   = 32;
  localparam int IDX_BITS  = 6;

  typedef struct packed {
    logic zero_div;
    logic sat;
  } tds_flags_t;
endpackage
`default_nettype wire

### src/tds_if.sv
`default_nettype none
interface tds_row_if;
  logic        valid;
  logic        ready;
  logic [31:0] sub_diag;
  logic [31:0] main_diag;
  logic [31:0] super_diag;
  logic [31:0] rhs_value;
  logic        row_last;
  modport source (output valid, sub_diag, main_diag, super_diag, rhs_value, row_last,
                  input ready);
  modport sink   (input valid, sub_diag, main_diag, super_diag, rhs_value, row_last,
                  output ready);
endinterface

interface tds_sol_if;
  logic        valid;
  logic        ready;
  logic [31:0] solution;
  logic [5:0]  row_index;
  logic        run_last;
  logic        divide_error;
  logic        overflow;
  modport source (output valid, solution, row_index, run_last, divide_error, overflow,
                  input ready);
  modport sink   (input valid, solution, row_index, run_last, divide_error, overflow,
                  output ready);
endinterface
`default_nettype wire

### src/tridiagonal_system_solver.sv
`default_nettype none
// Thomas-algorithm tridiagonal solver, signed fixed point (Q15.16 by default).
// rows: sink channel, one word per matrix row (a, b, c, d, row_last).
// sols: source channel, one word per unknown, last row first, down to row 0
//   (run_last set on row 0). divide_error/overflow are sticky for the system.
// Each row runs a forward step through one shared multiplier and one
// bit-serial divider. Row 0 needs two divisions; later rows need one
// division and four multiplies. A zero divisor skips the bit-serial
// steps of the divider.
// The last row starts the backward sweep: a silent pass settles the
// overflow flag, then a second pass emits one word per row and waits
// out any stall. ready stays low meanwhile.
// A stalled sink holds the output word and the sequencer waits.
// Reset (rst, synchronous) clears the row count and flags; the ratio
// memories are not cleared and are only read after being written.
// A row arriving when MAX_ROWS-1 rows are held is treated as last.
module tridiagonal_system_solver #(
  parameter int MAX_ROWS  = tds_pkg::MAX_ROWS,
  parameter int WORD_BITS = tds_pkg::WORD_BITS,
  parameter int FRAC_BITS = tds_pkg::FRAC_BITS
) (
  input wire logic clk,
  input wire logic rst,
  tds_row_if.sink  rows,
  tds_sol_if.source sols
);
  localparam int AB = $clog2(MAX_ROWS);
  localparam int W  = WORD_BITS;
  localparam int PW = 2 * W;
  localparam int IB = tds_pkg::IN_BITS;

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_M1, S_SUB, S_DIV, S_DWAIT, S_M2, S_M3, S_M4, S_WR,
    S_BRD, S_BMUL, S_BOUT
  } state_t;
  state_t state;

  logic signed [W-1:0] a, b, c, d, cp, dp, m, x, t;
  logic [AB-1:0] idx;
  logic [AB-1:0] top_idx;
  logic last, err, ovf;
  logic emit; // 0: silent backward pass, 1: emitting pass

  // shared multiplier
  logic signed [W-1:0]  mx, my;
  logic signed [PW-1:0] prod;
  logic signed [PW-FRAC_BITS-1:0] psh;
  logic signed [W-1:0]  pq;
  logic                 psat;
  assign prod = PW'(mx) * PW'(my);
  assign psh  = prod[PW-1:FRAC_BITS];
  always_comb begin
    psat = 1'b0; pq = psh[W-1:0];
    if (psh > (PW-FRAC_BITS)'(signed'({1'b0, {(W-1){1'b1}}}))) begin
      psat = 1'b1; pq = {1'b0, {(W-1){1'b1}}};
    end else if (psh < -(PW-FRAC_BITS)'(signed'({1'b0, {(W-1){1'b1}}})) - 1) begin
      psat = 1'b1; pq = {1'b1, {(W-1){1'b0}}};
    end
  end

  function automatic logic signed [W:0] sub_w(input logic signed [W-1:0] p,
                                               input logic signed [W-1:0] q);
    logic signed [W:0] s;
    s = {p[W-1], p} - {q[W-1], q};
    return s;
  endfunction
  logic signed [W:0] ds;
  logic signed [W-1:0] dsat;
  logic dsov;
  logic signed [W-1:0] sub_a, sub_b;
  assign ds = sub_w(sub_a, sub_b);
  always_comb begin
    dsov = ds[W] != ds[W-1];
    dsat = dsov ? {ds[W], {(W-1){~ds[W]}}} : ds[W-1:0];
  end

  function automatic logic signed [W-1:0] sat_in(input logic [IB-1:0] v,
                                                 output logic o);
    logic signed [IB-1:0] s;
    s = signed'(v);
    o = 1'b0;
    if (IB > W) begin
      if (s > IB'(signed'({1'b0, {(W-1){1'b1}}}))) begin
        o = 1'b1; return {1'b0, {(W-1){1'b1}}};
      end
      if (s < -IB'(signed'({1'b0, {(W-1){1'b1}}})) - 1) begin
        o = 1'b1; return {1'b1, {(W-1){1'b0}}};
      end
    end
    return W'(s);
  endfunction

  // divider
  logic div_start, div_done;
  logic signed [W-1:0] div_num, div_den, div_q;
  tds_pkg::tds_flags_t div_fl;
  tds_div #(.WORD_BITS(W), .FRAC_BITS(FRAC_BITS)) u_div (
    .clk, .rst, .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quo(div_q), .flags(div_fl)
  );

  // ratio memories
  logic we;
  logic [AB-1:0] waddr, raddr;
  logic [W-1:0] cr, dr;
  tds_ram #(.WIDTH(W), .DEPTH(MAX_ROWS)) u_cram (
    .clk, .we, .waddr, .wdata(cp), .raddr, .rdata(cr));
  tds_ram #(.WIDTH(W), .DEPTH(MAX_ROWS)) u_dram (
    .clk, .we, .waddr, .wdata(dp), .raddr, .rdata(dr));
  assign waddr = idx;
  assign we    = (state == S_WR);
  assign raddr = (state == S_BRD || state == S_BMUL || state == S_BOUT) ? idx : idx - 1'b1;

  logic o0, o1, o2, o3;
  logic phase; // 0: first division (c), 1: second (d) for row 0

  always_comb begin
    mx = a; my = cr; sub_a = b; sub_b = t;
    unique case (state)
      S_M1:   begin mx = a; my = cr; end
      S_SUB:  begin mx = a; my = dr; sub_a = b; sub_b = t; end
      S_M2:   begin mx = c; my = m; sub_a = d; sub_b = t; end
      S_M3:   begin mx = dp; my = m; end
      S_BMUL: begin mx = cr; my = x; end
      S_BOUT: begin mx = cr; my = x; sub_a = dr; sub_b = t; end
      default: ;
    endcase
  end

  assign rows.ready = (state == S_IDLE);
  assign div_start = (state == S_DIV);
  assign div_num = (idx == '0) ? (phase ? d : c) : W'(signed'({{(W-FRAC_BITS-1){1'b0}}, 1'b1,
                   {FRAC_BITS{1'b0}}}));
  assign div_den = (idx == '0) ? b : t;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; idx <= '0; err <= 1'b0; ovf <= 1'b0; sols.valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: if (rows.valid) begin
          a <= sat_in(rows.sub_diag, o0);
          b <= sat_in(rows.main_diag, o1);
          c <= sat_in(rows.super_diag, o2);
          d <= sat_in(rows.rhs_value, o3);
          ovf <= ovf | o0 | o1 | o2 | o3;
          last <= rows.row_last || (idx == AB'(MAX_ROWS - 1));
          phase <= 1'b0;
          state <= (idx == '0) ? S_DIV : S_RD;
        end
        S_RD:  state <= S_M1;
        S_M1:  begin t <= pq; ovf <= ovf | psat; state <= S_SUB; end
        S_SUB: begin
          t <= dsat;
          x <= pq;
          ovf <= ovf | dsov | psat;
          state <= S_DIV;
        end
        S_DIV: state <= S_DWAIT;
        S_DWAIT: if (div_done) begin
          err <= err | div_fl.zero_div; ovf <= ovf | div_fl.sat;
          if (idx == '0) begin
            if (!phase) begin cp <= div_q; phase <= 1'b1; state <= S_DIV; end
            else begin dp <= div_q; state <= S_WR; end
          end else begin
            m <= div_q; t <= x; state <= S_M2;
          end
        end
        S_M2: begin
          cp <= pq; dp <= dsat; ovf <= ovf | psat | dsov; state <= S_M3;
        end
        S_M3: begin dp <= pq; ovf <= ovf | psat; state <= S_WR; end
        S_WR: begin
          if (last) begin
            x <= dp; top_idx <= idx; emit <= 1'b0; state <= S_BRD;
          end else begin
            idx <= idx + 1'b1; state <= S_IDLE;
          end
        end
        S_BRD: begin
          sols.valid <= emit; sols.solution <= x; sols.row_index <= 6'(idx);
          sols.run_last <= (idx == '0);
          state <= S_M4;
        end
        S_M4: if (sols.ready || !emit) begin
          sols.valid <= 1'b0;
          if (idx == '0) begin
            if (emit) begin
              err <= 1'b0; ovf <= 1'b0; state <= S_IDLE;
            end else begin
              // flags are final now; rerun the sweep and send the words
              emit <= 1'b1; idx <= top_idx; x <= dp; state <= S_BRD;
            end
          end else begin
            idx <= idx - 1'b1; state <= S_BMUL;
          end
        end
        S_BMUL: begin t <= pq; ovf <= ovf | psat; state <= S_BOUT; end
        S_BOUT: begin
          x <= dsat; ovf <= ovf | dsov; state <= S_BRD;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // flags go out live: they are final before the first word goes out
  assign sols.divide_error = err;
  assign sols.overflow     = ovf;
endmodule
`default_nettype wire

### src/tds_ram.sv
`default_nettype none
module tds_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

### src/tds_div.sv
`default_nettype none
// Restoring divider, one quotient bit a cycle. Quotient = trunc(num*2^F/den), saturated.
module tds_div #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic signed [WORD_BITS-1:0] num,
  input  wire logic signed [WORD_BITS-1:0] den,
  output logic                             done,
  output logic signed [WORD_BITS-1:0]      quo,
  output tds_pkg::tds_flags_t              flags
);
  localparam int NB = WORD_BITS + FRAC_BITS;
  localparam int CB = $clog2(NB + 1);
  logic [NB-1:0]      dividend;
  logic [NB-1:0]      q;
  logic [WORD_BITS:0] rem;
  logic [WORD_BITS:0] dmag;
  logic               neg;
  logic               busy;
  logic [CB-1:0]      cnt;
  logic [WORD_BITS+1:0] trial;
  logic [NB:0]        qs;
  logic [NB:0]        lim;

  assign trial = {rem, dividend[NB-1]} - {1'b0, dmag};

  always_comb begin
    qs  = neg ? -{1'b0, q} : {1'b0, q};
    lim = neg ? {{(NB-WORD_BITS+1){1'b1}}, 1'b1, {(WORD_BITS-1){1'b0}}}
              : {{(NB-WORD_BITS+2){1'b0}}, {(WORD_BITS-1){1'b1}}};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        if (den == '0) begin
          done  <= 1'b1;
          quo   <= '0;
          flags <= '{zero_div: 1'b1, sat: 1'b0};
        end else begin
          busy     <= 1'b1;
          cnt      <= CB'(NB);
          neg      <= num[WORD_BITS-1] ^ den[WORD_BITS-1];
          // the most negative num negates to itself, which reads as 2^(W-1) unsigned
          dividend <= {(num[WORD_BITS-1] ? -num : num), {FRAC_BITS{1'b0}}};
          dmag     <= den[WORD_BITS-1] ? -{den[WORD_BITS-1], den} : {1'b0, den};
          rem      <= '0;
          q        <= '0;
        end
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
          if (!neg && q > lim[NB-1:0]) begin
            quo <= {1'b0, {(WORD_BITS-1){1'b1}}}; flags <= '{zero_div: 1'b0, sat: 1'b1};
          end else if (neg && q > {{(NB-WORD_BITS){1'b0}}, 1'b1, {(WORD_BITS-1){1'b0}}}) begin
            quo <= {1'b1, {(WORD_BITS-1){1'b0}}}; flags <= '{zero_div: 1'b0, sat: 1'b1};
          end else begin
            quo <= qs[WORD_BITS-1:0]; flags <= '0;
          end
        end else begin
          cnt      <= cnt - 1'b1;
          dividend <= dividend << 1;
          if (!trial[WORD_BITS+1]) begin
            rem <= trial[WORD_BITS:0];
            q   <= {q[NB-2:0], 1'b1};
          end else begin
            rem <= {rem[WORD_BITS-1:0], dividend[NB-1]};
            q   <= {q[NB-2:0], 1'b0};
          end
        end
      end
    end
  end
endmodule
`default_nettype wire

### src/tds_checker.sv
`default_nettype none
module tds_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic run_last,
  input wire logic [5:0] row_index
);
  a_excl: assert property (@(posedge clk) disable iff (rst) !(in_ready && out_valid))
    else $error("input ready during output");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(row_index))
    else $error("output dropped under stall");
  a_last: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (run_last == (row_index == 6'd0)))
    else $error("run_last mismatch");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("ready right after accept");
endmodule

bind tridiagonal_system_solver tds_checker u_chk (
  .clk, .rst, .in_valid(rows.valid), .in_ready(rows.ready),
  .out_valid(sols.valid), .out_ready(sols.ready),
  .run_last(sols.run_last), .row_index(sols.row_index)
);
`default_nettype wire
